>>> src/smdalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smdalu_pkg;

    // Opcodes carried on the op field
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_MOD = 3'd5;

    // Commands from the sequencer to the shared datapath
    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_HOLD    = 3'd0;
    localparam cmd_t CMD_CAPTURE = 3'd1;
    localparam cmd_t CMD_SIMPLE  = 3'd2;
    localparam cmd_t CMD_MAG_A   = 3'd3;
    localparam cmd_t CMD_MAG_B   = 3'd4;
    localparam cmd_t CMD_STEP    = 3'd5;
    localparam cmd_t CMD_FIX     = 3'd6;

    typedef struct packed {
        logic long_op;
        logic div_zero;
    } status_t;

endpackage

`default_nettype wire

>>> src/smdalu_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module smdalu_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                          clk,
    input  smdalu_pkg::cmd_t             cmd,
    input  wire [2:0]                    op_in,
    input  wire signed [DATA_WIDTH-1:0]  a_in,
    input  wire signed [DATA_WIDTH-1:0]  b_in,
    output logic [DATA_WIDTH-1:0]        value,
    output smdalu_pkg::status_t          status
);

    localparam int N = DATA_WIDTH;

    logic [2:0]   op_reg,     op_next;
    logic [N-1:0] a_reg,      a_next;
    logic [N-1:0] b_reg,      b_next;
    logic [N-1:0] acc_reg,    acc_next;
    logic [N-1:0] mcand_reg,  mcand_next;
    logic [N-1:0] mplier_reg, mplier_next;

    logic [N-1:0] add_x;
    logic [N-1:0] add_y;
    logic         add_sub;
    logic [N:0]   sum_ext;
    logic [N-1:0] sum;

    logic         is_mul;
    logic         is_div;
    logic         is_mod;
    logic         a_neg;
    logic         b_neg;
    logic         b_zero;
    logic [N-1:0] rem_sh;
    logic         q_bit;
    logic [N-1:0] fix_val;
    logic         fix_neg;

    assign is_mul = (op_reg == smdalu_pkg::OP_MUL);
    assign is_div = (op_reg == smdalu_pkg::OP_DIV);
    assign is_mod = (op_reg == smdalu_pkg::OP_MOD);
    assign a_neg  = a_reg[N-1];
    assign b_neg  = b_reg[N-1];
    assign b_zero = (b_reg == '0);

    // Shared adder: x + y, or x - y as x + ~y + 1
    assign sum_ext = {1'b0, add_x} + {1'b0, add_y ^ {N{add_sub}}} + {{N{1'b0}}, add_sub};
    assign sum     = sum_ext[N-1:0];

    // Restoring division step: shift next dividend bit into the partial remainder
    assign rem_sh  = {acc_reg[N-2:0], mplier_reg[N-1]};
    assign q_bit   = acc_reg[N-1] | sum_ext[N];

    assign fix_val = is_div ? mplier_reg : acc_reg;
    assign fix_neg = is_mod ? a_neg : (a_neg ^ b_neg);

    always_comb
    begin
        add_x = '0;
        add_y = '0;
        add_sub = 1'b0;
        unique case (cmd)
            smdalu_pkg::CMD_SIMPLE:
            begin
                unique case (op_reg)
                    smdalu_pkg::OP_ADD:
                    begin
                        add_x = a_reg;
                        add_y = b_reg;
                    end
                    smdalu_pkg::OP_SUB:
                    begin
                        add_x = a_reg;
                        add_y = b_reg;
                        add_sub = 1'b1;
                    end
                    smdalu_pkg::OP_NEG:
                    begin
                        add_y = a_reg;
                        add_sub = 1'b1;
                    end
                    default:
                    begin
                        add_x = '0;
                    end
                endcase
            end
            smdalu_pkg::CMD_MAG_A:
            begin
                add_y = a_reg;
                add_sub = 1'b1;
            end
            smdalu_pkg::CMD_MAG_B:
            begin
                add_y = b_reg;
                add_sub = 1'b1;
            end
            smdalu_pkg::CMD_STEP:
            begin
                if (is_mul)
                begin
                    add_x = acc_reg;
                    add_y = mcand_reg;
                end
                else
                begin
                    add_x = rem_sh;
                    add_y = mcand_reg;
                    add_sub = 1'b1;
                end
            end
            smdalu_pkg::CMD_FIX:
            begin
                add_y = fix_val;
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        op_next = op_reg;
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        unique case (cmd)
            smdalu_pkg::CMD_CAPTURE:
            begin
                op_next = op_in;
                a_next = a_in;
                b_next = b_in;
            end
            smdalu_pkg::CMD_SIMPLE:
            begin
                acc_next = sum;
            end
            smdalu_pkg::CMD_MAG_A:
            begin
                acc_next = '0;
                if (is_mul)
                    mcand_next = a_neg ? sum : a_reg;
                else
                    mplier_next = a_neg ? sum : a_reg;
            end
            smdalu_pkg::CMD_MAG_B:
            begin
                if (is_mul)
                    mplier_next = b_neg ? sum : b_reg;
                else
                    mcand_next = b_neg ? sum : b_reg;
            end
            smdalu_pkg::CMD_STEP:
            begin
                if (is_mul)
                begin
                    if (mplier_reg[0])
                        acc_next = sum;
                    mcand_next = {mcand_reg[N-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[N-1:1]};
                end
                else
                begin
                    acc_next = q_bit ? sum : rem_sh;
                    mplier_next = {mplier_reg[N-2:0], q_bit};
                end
            end
            smdalu_pkg::CMD_FIX:
            begin
                if (b_zero && is_div)
                    acc_next = '0;
                else if (b_zero && is_mod)
                    acc_next = a_reg;
                else
                    acc_next = fix_neg ? sum : fix_val;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_reg <= a_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign value = acc_reg;
    assign status = '{long_op: is_mul | is_div | is_mod,
                      div_zero: b_zero & (is_div | is_mod)};

endmodule

`default_nettype wire

>>> src/signed_mul_div_alu_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Valid/Ready            Payload
// req      req_valid/req_ready    op, operand_a, operand_b
// rsp      rsp_valid/rsp_ready    result, divide_by_zero
//
// Add, subtract, negate and unused opcodes: capture the operands, one pass
// through the shared adder, then the output register. Multiply, divide, modulo:
// decode the opcode, take the magnitudes of A and B, one bit per cycle through
// the shared adder, fix the sign, then the output register. The output register
// is loaded only once it is free.
// Reset clears the sequencer and the output valid; no clearing pass.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits at its end until the output register frees.

module signed_mul_div_alu_core #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          req_valid,
    output logic                         req_ready,
    input  wire [2:0]                    op,
    input  wire signed [DATA_WIDTH-1:0]  operand_a,
    input  wire signed [DATA_WIDTH-1:0]  operand_b,
    output logic                         rsp_valid,
    input  wire                          rsp_ready,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic                         divide_by_zero
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SIMPLE = 3'd1;
    localparam logic [2:0] S_MAG_A  = 3'd2;
    localparam logic [2:0] S_MAG_B  = 3'd3;
    localparam logic [2:0] S_ITER   = 3'd4;
    localparam logic [2:0] S_FIX    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]            state_reg,  state_next;
    logic [CNT_W-1:0]      cnt_reg,    cnt_next;
    logic                  valid_reg,  valid_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;
    logic                  dz_reg,     dz_next;

    smdalu_pkg::cmd_t      cmd;
    smdalu_pkg::status_t   status;
    logic [DATA_WIDTH-1:0] unit_value;
    logic                  accept;
    logic                  out_free;

    smdalu_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_unit (
        .clk    (clk),
        .cmd    (cmd),
        .op_in  (op),
        .a_in   (operand_a),
        .b_in   (operand_b),
        .value  (unit_value),
        .status (status)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid & req_ready;
    assign out_free  = ~valid_reg | rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        valid_next = valid_reg;
        result_next = result_reg;
        dz_next = dz_reg;
        cmd = smdalu_pkg::CMD_HOLD;

        if (valid_reg && rsp_ready)
            valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd = smdalu_pkg::CMD_CAPTURE;
                    state_next = S_SIMPLE;
                end
            end
            S_SIMPLE:
            begin
                // Long ops branch off here; short ops finish in one pass
                if (status.long_op)
                begin
                    state_next = S_MAG_A;
                end
                else
                begin
                    cmd = smdalu_pkg::CMD_SIMPLE;
                    state_next = S_DONE;
                end
            end
            S_MAG_A:
            begin
                cmd = smdalu_pkg::CMD_MAG_A;
                state_next = S_MAG_B;
            end
            S_MAG_B:
            begin
                cmd = smdalu_pkg::CMD_MAG_B;
                cnt_next = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                cmd = smdalu_pkg::CMD_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_WIDTH - 1))
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd = smdalu_pkg::CMD_FIX;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register frees
                if (out_free)
                begin
                    valid_next = 1'b1;
                    result_next = unit_value;
                    dz_next = status.div_zero;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        dz_reg <= dz_next;
    end

    assign rsp_valid      = valid_reg;
    assign result         = result_reg;
    assign divide_by_zero = dz_reg;

endmodule

`default_nettype wire

>>> src/smdalu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module smdalu_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  req_valid,
    input wire                  req_ready,
    input wire                  rsp_valid,
    input wire                  rsp_ready,
    input wire [DATA_WIDTH-1:0] result,
    input wire                  divide_by_zero
);

    // Busy right after taking a request beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one still in work");

    // A new result beat only appears as the unit returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> (!$past(req_ready) && req_ready))
    else $error("result beat appeared outside completion");

    // Stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> ($stable(result) && $stable(divide_by_zero)))
    else $error("result payload changed while stalled");

endmodule

bind signed_mul_div_alu_core smdalu_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_smdalu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .result         (result),
    .divide_by_zero (divide_by_zero)
);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WIDTH = 32;
    localparam int RANDOM_BEATS = 1850;

    // Unused opcodes: the block answers zero with no flag
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam logic signed [WIDTH-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [WIDTH-1:0] MOST_POS = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [WIDTH-1:0] value;
        logic                    dz;
    } alu_out_t;

    typedef struct packed {
        logic [2:0]              opc;
        logic signed [WIDTH-1:0] a;
        logic signed [WIDTH-1:0] b;
        logic                    typed;
        logic signed [WIDTH-1:0] value;
        logic                    dz;
    } row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_ready;
    logic [2:0]              op = smdalu_pkg::OP_ADD;
    logic signed [WIDTH-1:0] operand_a = '0;
    logic signed [WIDTH-1:0] operand_b = '0;
    logic                    rsp_valid;
    logic                    rsp_ready = 1'b0;
    logic signed [WIDTH-1:0] result;
    logic                    divide_by_zero;

    alu_out_t pending_results[$];
    int       mismatches = 0;
    int       idle_pct = 10;

    // Directed beats; typed expectations only where the answer is obvious
    row_t directed_rows [25] = '{
        '{smdalu_pkg::OP_ADD, 32'sd0,   32'sd0,         1'b1, 32'sd0,   1'b0},
        '{smdalu_pkg::OP_ADD, MOST_POS, 32'sd1,         1'b1, MOST_NEG, 1'b0},
        '{smdalu_pkg::OP_ADD, MOST_NEG, MOST_NEG,       1'b1, 32'sd0,   1'b0},
        '{smdalu_pkg::OP_ADD, -32'sd1,  -32'sd1,        1'b1, -32'sd2,  1'b0},
        '{smdalu_pkg::OP_SUB, MOST_NEG, 32'sd1,         1'b1, MOST_POS, 1'b0},
        '{smdalu_pkg::OP_SUB, 32'sd0,   MOST_NEG,       1'b1, MOST_NEG, 1'b0},
        '{smdalu_pkg::OP_SUB, 32'sd3,   32'sd10,        1'b0, 32'sd0,   1'b0},
        '{smdalu_pkg::OP_NEG, MOST_NEG, 32'sh5A5A_5A5A, 1'b1, MOST_NEG, 1'b0},
        '{smdalu_pkg::OP_NEG, 32'sd5,   MOST_POS,       1'b1, -32'sd5,  1'b0},
        '{smdalu_pkg::OP_MUL, MOST_POS, MOST_POS,       1'b0, 32'sd0,   1'b0},
        '{smdalu_pkg::OP_MUL, MOST_NEG, -32'sd1,        1'b1, MOST_NEG, 1'b0},
        '{smdalu_pkg::OP_MUL, -32'sd7,  32'sd6,         1'b1, -32'sd42, 1'b0},
        '{smdalu_pkg::OP_MUL, MOST_NEG, MOST_NEG,       1'b0, 32'sd0,   1'b0},
        '{smdalu_pkg::OP_DIV, 32'sd7,   32'sd0,         1'b1, 32'sd0,   1'b1},
        '{smdalu_pkg::OP_DIV, MOST_NEG, 32'sd0,         1'b1, 32'sd0,   1'b1},
        '{smdalu_pkg::OP_MOD, -32'sd9,  32'sd0,         1'b1, -32'sd9,  1'b1},
        '{smdalu_pkg::OP_DIV, MOST_NEG, -32'sd1,        1'b1, MOST_NEG, 1'b0},
        '{smdalu_pkg::OP_MOD, MOST_NEG, -32'sd1,        1'b1, 32'sd0,   1'b0},
        '{smdalu_pkg::OP_DIV, -32'sd7,  32'sd2,         1'b1, -32'sd3,  1'b0},
        '{smdalu_pkg::OP_MOD, -32'sd7,  32'sd2,         1'b1, -32'sd1,  1'b0},
        '{smdalu_pkg::OP_MOD, 32'sd7,   -32'sd2,        1'b1, 32'sd1,   1'b0},
        '{smdalu_pkg::OP_DIV, MOST_POS, MOST_NEG,       1'b0, 32'sd0,   1'b0},
        '{smdalu_pkg::OP_DIV, MOST_NEG, MOST_NEG,       1'b1, 32'sd1,   1'b0},
        '{OP_SPARE6,          MOST_POS, MOST_NEG,       1'b1, 32'sd0,   1'b0},
        '{OP_SPARE7,          -32'sd1,  -32'sd1,        1'b1, 32'sd0,   1'b0}
    };

    signed_mul_div_alu_core #(
        .DATA_WIDTH(WIDTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .op            (op),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .result        (result),
        .divide_by_zero(divide_by_zero)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [WIDTH:0] magnitude_of(logic signed [WIDTH-1:0] x);
        return x[WIDTH-1] ? ((33'd1 << WIDTH) - {1'b0, x}) : {1'b0, x};
    endfunction

    // Truncating signed division on magnitudes; zero divisor flagged, quotient 0, remainder the dividend
    function automatic alu_out_t arith_result(logic [2:0] opc,
                                              logic signed [WIDTH-1:0] a,
                                              logic signed [WIDTH-1:0] b);
        alu_out_t        r;
        logic [WIDTH-1:0] quot;
        r.value = '0;
        r.dz    = 1'b0;
        quot    = '0;
        if (b != 0)
        begin
            quot = WIDTH'(magnitude_of(a) / magnitude_of(b));
            if (a[WIDTH-1] != b[WIDTH-1])
                quot = -quot;
        end
        case (opc)
            smdalu_pkg::OP_ADD: r.value = a + b;
            smdalu_pkg::OP_SUB: r.value = a - b;
            smdalu_pkg::OP_NEG: r.value = -a;
            smdalu_pkg::OP_MUL: r.value = a * b;
            smdalu_pkg::OP_DIV:
            begin
                r.value = quot;
                r.dz    = (b == 0);
            end
            smdalu_pkg::OP_MOD:
            begin
                r.value = a - quot * b;
                r.dz    = (b == 0);
            end
            default: r.value = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [WIDTH-1:0] pick_operand();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'sd1;
            2: return -32'sd1;
            3: return MOST_NEG;
            4: return MOST_POS;
            5, 6: return $signed($urandom_range(200)) - 32'sd100;
            default: return $urandom;
        endcase
    endfunction

    // Drive one beat and record what it should produce once it is taken
    task automatic send_beat(logic [2:0] opc, logic signed [WIDTH-1:0] a,
                             logic signed [WIDTH-1:0] b, logic typed,
                             alu_out_t typed_out);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= opc;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (!req_ready);
        pending_results.push_back(typed ? typed_out : arith_result(opc, a, b));
    endtask

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Compare every accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        alu_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: result=%0d dz=%0b",
                             result, divide_by_zero);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.value || divide_by_zero !== want.dz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: result exp %0d got %0d, dz exp %0b got %0b",
                                 want.value, result, want.dz, divide_by_zero);
                end
            end
        end
    end

    initial
    begin
        alu_out_t    typed_out;
        logic [2:0]  opc;
        int          pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_out.value = directed_rows[i].value;
            typed_out.dz    = directed_rows[i].dz;
            send_beat(directed_rows[i].opc, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].typed, typed_out);
        end

        typed_out = '0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // hold both sides busy through the middle stretch
            idle_pct = (n >= 700 && n < 1100) ? 0 : 10;
            pick = $urandom_range(99);
            if (pick < 2)
                opc = OP_SPARE6 + 3'($urandom_range(1));
            else
                opc = 3'($urandom_range(5));
            send_beat(opc, pick_operand(), pick_operand(), 1'b0, typed_out);
        end
        req_valid <= 1'b0;
        idle_pct = 10;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
